### hw/rtl/tpc_pkg.sv
package tpc_pkg;

  localparam int unsigned CURV_W = 17;
  localparam logic [CURV_W-1:0] THRESH_RESET = 17'd655;

  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

endpackage

### hw/rtl/tpc_in_if.sv
interface tpc_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;

  modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
  modport sink (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

### hw/rtl/tpc_out_if.sv
interface tpc_out_if;
  import tpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CURV_W-1:0] curvature;
  logic              is_straight;
  logic              degenerate;

  modport source (output valid, curvature, is_straight, degenerate, input ready);
  modport sink (input valid, curvature, is_straight, degenerate, output ready);
endinterface

### hw/rtl/tpc_mul.sv
module tpc_mul #(
  parameter int unsigned AW = 35,
  parameter int unsigned BW = 35
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);
  localparam int unsigned CH = 17;
  localparam int unsigned NA = (AW + CH - 1) / CH;
  localparam int unsigned NB = (BW + CH - 1) / CH;
  localparam int unsigned SW = NA * CH + NB * CH;

  logic [NA*CH-1:0]  a_ext;
  logic [NB*CH-1:0]  b_ext;
  logic [2*CH-1:0]   pp_q [NA*NB];
  logic [SW-1:0]     acc;
  logic [AW+BW-1:0]  p_q;

  assign a_ext = (NA*CH)'(a_i);
  assign b_ext = (NB*CH)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i*NB+j] <= (2*CH)'(a_ext[i*CH+:CH]) * (2*CH)'(b_ext[j*CH+:CH]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp_q[i*NB+j]) << ((i + j) * CH));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (AW+BW)'(acc);
    end
  end

  assign p_o = p_q;
endmodule

### hw/rtl/tpc_cell.sv
module tpc_cell #(
  parameter int unsigned TW  = 141,
  parameter int unsigned BIT = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  tpc_pkg::ctl_t             ctl_i,
  input  logic [TW-1:0]             p_i,
  input  logic [TW-1:0]             r_i,
  input  logic [TW-1:0]             y_i,
  input  logic [tpc_pkg::CURV_W-1:0] q_i,
  output tpc_pkg::ctl_t             ctl_o,
  output logic [TW-1:0]             p_o,
  output logic [TW-1:0]             r_o,
  output logic [TW-1:0]             y_o,
  output logic [tpc_pkg::CURV_W-1:0] q_o
);
  import tpc_pkg::*;

  logic [TW-1:0]     term;
  logic              take;
  ctl_t              ctl_q;
  logic [TW-1:0]     p_q, r_q, y_q;
  logic [CURV_W-1:0] q_q;

  // Trying q + 2^b adds (2^(b+1) q + 2^(2b)) P to q^2 P.
  assign term = (y_i << (BIT + 1)) + (p_i << (2 * BIT));
  assign take = (term <= r_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_i;
      r_q <= take ? r_i - term : r_i;
      y_q <= take ? y_i + (p_i << BIT) : y_i;
      q_q <= take ? (q_i | (CURV_W'(1) << BIT)) : q_i;
    end
  end

  assign ctl_o = ctl_q;
  assign p_o   = p_q;
  assign r_o   = r_q;
  assign y_o   = y_q;
  assign q_o   = q_q;
endmodule

### hw/rtl/three_point_curvature.sv
// Menger curvature of three points, one item per cycle when the output side keeps up.
// Pipeline stages, each registered: one for differences, one for squares and cross terms,
// one for sums, four for the two chained wide products, seventeen for the row of search
// cells that settle one result bit each, and the output register. All stages move
// together; a stalled output holds the whole pipeline.
module three_point_curvature #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tpc_pkg::CURV_W-1:0] cfg_wdata_i,
  tpc_in_if.sink                     in_i,
  tpc_out_if.source                  out_o
);
  import tpc_pkg::*;

  localparam int unsigned D  = COORD_BITS + 1;
  localparam int unsigned SQ = 2 * D;
  localparam int unsigned L  = SQ + 1;
  localparam int unsigned X  = SQ + 1;
  localparam int unsigned PW = 3 * L;
  localparam int unsigned RW = 2 * X + 34;
  localparam int unsigned TW = (PW + 36 > RW) ? PW + 36 : RW;
  localparam int unsigned NC = CURV_W;

  logic              adv;
  logic [CURV_W-1:0] thresh_q;

  // Stage 1
  ctl_t                c1_q;
  logic signed [D-1:0] dabx_q, daby_q, dbcx_q, dbcy_q, dacx_q, dacy_q;
  // Stage 2
  ctl_t                 c2_q;
  logic signed [SQ-1:0] m_abx, m_aby, m_bcx, m_bcy, m_acx, m_acy, m_k1, m_k2;
  logic [SQ-1:0]        sabx_q, saby_q, sbcx_q, sbcy_q, sacx_q, sacy_q;
  logic signed [SQ-1:0] k1_q, k2_q;
  // Stage 3
  ctl_t                c3_q;
  logic [L-1:0]        ab2_q, bc2_q, ac2_q;
  logic [X-1:0]        acr_q;
  logic signed [X-1:0] cr;
  logic [L-1:0]        ab2_d, bc2_d, ac2_d;
  // Products
  ctl_t           c4_q, c5_q, c6_q, c7_q;
  logic [L-1:0]   ac2_4_q, ac2_5_q;
  logic [2*L-1:0] m1;
  logic [2*X-1:0] mx;
  logic [2*X-1:0] mx_6_q, mx_7_q;
  logic [PW-1:0]  pp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
      c7_q <= '0;
    end else if (adv) begin
      c1_q <= '{valid: in_i.valid, degen: 1'b0};
      c2_q <= c1_q;
      c3_q <= '{valid: c2_q.valid,
                degen: (ab2_d == '0) || (bc2_d == '0) || (ac2_d == '0)};
      c4_q <= c3_q;
      c5_q <= c4_q;
      c6_q <= c5_q;
      c7_q <= c6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dabx_q <= $signed({in_i.bx[COORD_BITS-1], in_i.bx}) -
                $signed({in_i.ax[COORD_BITS-1], in_i.ax});
      daby_q <= $signed({in_i.by[COORD_BITS-1], in_i.by}) -
                $signed({in_i.ay[COORD_BITS-1], in_i.ay});
      dbcx_q <= $signed({in_i.cx[COORD_BITS-1], in_i.cx}) -
                $signed({in_i.bx[COORD_BITS-1], in_i.bx});
      dbcy_q <= $signed({in_i.cy[COORD_BITS-1], in_i.cy}) -
                $signed({in_i.by[COORD_BITS-1], in_i.by});
      dacx_q <= $signed({in_i.cx[COORD_BITS-1], in_i.cx}) -
                $signed({in_i.ax[COORD_BITS-1], in_i.ax});
      dacy_q <= $signed({in_i.cy[COORD_BITS-1], in_i.cy}) -
                $signed({in_i.ay[COORD_BITS-1], in_i.ay});
    end
  end

  assign m_abx = dabx_q * dabx_q;
  assign m_aby = daby_q * daby_q;
  assign m_bcx = dbcx_q * dbcx_q;
  assign m_bcy = dbcy_q * dbcy_q;
  assign m_acx = dacx_q * dacx_q;
  assign m_acy = dacy_q * dacy_q;
  assign m_k1  = dabx_q * dacy_q;
  assign m_k2  = daby_q * dacx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sabx_q <= $unsigned(m_abx);
      saby_q <= $unsigned(m_aby);
      sbcx_q <= $unsigned(m_bcx);
      sbcy_q <= $unsigned(m_bcy);
      sacx_q <= $unsigned(m_acx);
      sacy_q <= $unsigned(m_acy);
      k1_q   <= m_k1;
      k2_q   <= m_k2;
    end
  end

  assign ab2_d = L'(sabx_q) + L'(saby_q);
  assign bc2_d = L'(sbcx_q) + L'(sbcy_q);
  assign ac2_d = L'(sacx_q) + L'(sacy_q);
  assign cr    = $signed({k1_q[SQ-1], k1_q}) - $signed({k2_q[SQ-1], k2_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ab2_q   <= ab2_d;
      bc2_q   <= bc2_d;
      ac2_q   <= ac2_d;
      acr_q   <= cr[X-1] ? $unsigned(-cr) : $unsigned(cr);
      ac2_4_q <= ac2_q;
      ac2_5_q <= ac2_4_q;
      mx_6_q  <= mx;
      mx_7_q  <= mx_6_q;
    end
  end

  tpc_mul #(.AW(L), .BW(L)) u_mul_ab_bc (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (ab2_q),
    .b_i   (bc2_q),
    .p_o   (m1)
  );

  tpc_mul #(.AW(X), .BW(X)) u_mul_cross (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (acr_q),
    .b_i   (acr_q),
    .p_o   (mx)
  );

  tpc_mul #(.AW(2*L), .BW(L)) u_mul_ac (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (m1),
    .b_i   (ac2_5_q),
    .p_o   (pp)
  );

  ctl_t              cc  [NC+1];
  logic [TW-1:0]     cp  [NC+1];
  logic [TW-1:0]     crm [NC+1];
  logic [TW-1:0]     cy  [NC+1];
  logic [CURV_W-1:0] cq  [NC+1];

  assign cc[0]  = c7_q;
  assign cp[0]  = TW'(pp);
  assign crm[0] = TW'(mx_7_q) << 34;
  assign cy[0]  = '0;
  assign cq[0]  = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    tpc_cell #(.TW(TW), .BIT(NC - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (cc[g]),
      .p_i    (cp[g]),
      .r_i    (crm[g]),
      .y_i    (cy[g]),
      .q_i    (cq[g]),
      .ctl_o  (cc[g+1]),
      .p_o    (cp[g+1]),
      .r_o    (crm[g+1]),
      .y_o    (cy[g+1]),
      .q_o    (cq[g+1])
    );
  end

  logic              out_vld_q;
  logic [CURV_W-1:0] curv_q;
  logic [CURV_W-1:0] curv_d;
  logic              str_q, deg_q;

  assign adv    = !out_vld_q || out_o.ready;
  assign curv_d = cc[NC].degen ? '0 : cq[NC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= cc[NC].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      curv_q <= curv_d;
      str_q  <= (curv_d < thresh_q);
      deg_q  <= cc[NC].degen;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.curvature   = curv_q;
  assign out_o.is_straight = str_q;
  assign out_o.degenerate  = deg_q;
endmodule
